/* rtl/ddo_pkg.sv */
// Shared constants, tables and helpers for the differential drive odometry block.
`default_nettype none
package ddo_pkg;

   // Rotation arithmetic runs on 34-bit signed Q2.30 values.
   localparam int TRIG_W         = 34;
   localparam int TRIG_TABLE_LEN = 24;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [TRIG_W-1:0] ANGLE_QUARTER   = 34'sd1073741824;
   localparam logic signed [TRIG_W-1:0] ANGLE_HALF      = 34'sd2147483648;

   // Datapath widths of the two serial multiplies.
   localparam int SUM_W   = 34;
   localparam int PROD1_W = 54;
   localparam int DIST_W  = 45;
   localparam int TURN_W  = 25;
   localparam int PROD2_W = 61;

   // Configuration register indexes.
   localparam logic [2:0] REG_DIST_PER_TICK  = 3'd0;
   localparam logic [2:0] REG_ANGLE_PER_TICK = 3'd1;
   localparam logic [2:0] REG_INITIAL_X      = 3'd2;
   localparam logic [2:0] REG_INITIAL_Y      = 3'd3;
   localparam logic [2:0] REG_INITIAL_HEAD   = 3'd4;

   // Arctangent of 2^-i in 32-bit binary angle units.
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2E;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // Round a Q2.30 value to Q1.15, half up, and clamp to the 16-bit range.
   function automatic logic signed [15:0] to_q15(input logic signed [TRIG_W-1:0] v);
      logic signed [TRIG_W-1:0] t;
      logic signed [15:0]       r;
      t = (v + 34'sd16384) >>> 15;
      if (t > 34'sd32767) begin
         r = 16'sh7FFF;
      end else if (t < -34'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = t[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/ddo_cordic.sv */
// Iterative rotation unit giving cosine and sine of a 16-bit binary angle.
`default_nettype none
module ddo_cordic #(
   parameter int TRIG_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [15:0]        angle,
   output logic                    done,
   output logic signed [15:0]      cos_q15,
   output logic signed [15:0]      sin_q15
);
   import ddo_pkg::*;

   localparam int CNT_W = $clog2(TRIG_STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TRIG_STEPS - 1);

   logic                     run_ff, run_in;
   logic                     cvt_ff, cvt_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                     flip_ff, flip_in;
   logic signed [15:0]       cos_ff, cos_in, sin_ff, sin_in;

   logic signed [TRIG_W-1:0] z0, xs, ys, at, vx, vy;

   always_comb begin
      run_in  = run_ff;
      cvt_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;

      z0 = {{2{angle[15]}}, angle, 16'h0000};
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      at = {2'b00, atan_turn(5'(cnt_ff))};
      vx = flip_ff ? -x_ff : x_ff;
      vy = flip_ff ? -y_ff : y_ff;

      if (start) begin
         // Fold the angle into the right half plane; the result is negated later.
         run_in  = 1'b1;
         cnt_in  = '0;
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         flip_in = 1'b0;
         z_in    = z0;
         if (z0 > ANGLE_QUARTER) begin
            z_in    = z0 - ANGLE_HALF;
            flip_in = 1'b1;
         end else if (z0 < -ANGLE_QUARTER) begin
            z_in    = z0 + ANGLE_HALF;
            flip_in = 1'b1;
         end
      end else if (run_ff) begin
         if (!z_ff[TRIG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in = 1'b0;
            cvt_in = 1'b1;
         end
      end else if (cvt_ff) begin
         cos_in  = to_q15(vx);
         sin_in  = to_q15(vy);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cvt_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         cvt_ff  <= cvt_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_q15 = cos_ff;
   assign sin_q15 = sin_ff;

endmodule
`default_nettype wire

/* rtl/differential_drive_odometry.sv */
// Top level of the differential drive wheel odometry block.
`default_nettype none
// Each accepted word carries the current left and right encoder counters; the
// block forms the wrapped tick deltas, the mean travel and the turn, and returns
// one word with the new pose (x and y in Q8 millimetres, saturated, and the
// heading in 65536 units per turn). From acceptance to the result, a word passes
// through a bit-serial multiply over the distance-per-tick register (the turn
// multiply runs alongside), a setup step, TRIG_STEPS rotation steps plus a
// conversion step and a handover step in the sine/cosine unit, a bit-serial
// multiply over the cosine and sine, and the pose update. The input is stalled
// for that whole time, and the pose update itself waits while an earlier result
// is still held in the output register. A new word is taken once the pose is
// updated, even while the previous result still waits in the output register.
// Writing an initial pose register loads the pose at once; writes must come
// only when idle, which the block itself does not enforce.
module differential_drive_odometry #(
   parameter int TRIG_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_left_count,
   input  wire logic signed [31:0] req_right_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic [15:0]             rsp_heading,
   input  wire logic               csr_write,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import ddo_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL1 = 6'b000010,
      ST_PREP = 6'b000100,
      ST_TRIG = 6'b001000,
      ST_MUL2 = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   localparam logic [4:0] MUL1_LAST = 5'd19;
   localparam logic [4:0] MUL2_LAST = 5'd15;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   // Configuration and pose state.
   logic [19:0]        dpt_ff, dpt_in;
   logic [15:0]        apt_ff, apt_in;
   logic signed [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [15:0]        cur_hd_ff, cur_hd_in;
   logic [31:0]        last_l_ff, last_l_in, last_r_ff, last_r_in;

   // First multiply: distance product and turn product, one multiplier bit a cycle.
   logic signed [PROD1_W-1:0] m1_acc_ff, m1_acc_in, m1_mc_ff, m1_mc_in;
   logic [19:0]               m1_mp_ff, m1_mp_in;
   logic [TURN_W-1:0]         t_acc_ff, t_acc_in, t_mc_ff, t_mc_in;
   logic [15:0]               t_mp_ff, t_mp_in;
   logic [15:0]               full_ff, full_in;

   // Second multiply: distance times cosine and sine.
   logic signed [PROD2_W-1:0] ax_ff, ax_in, ay_ff, ay_in, m2_mc_ff, m2_mc_in;
   logic [15:0]               cx_ff, cx_in, sy_ff, sy_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [15:0]         out_hd_ff, out_hd_in;

   logic                trig_start, trig_done;
   logic [15:0]         trig_angle;
   logic signed [15:0]  trig_cos, trig_sin;

   logic                     accept;
   logic [31:0]              dl, dr;
   logic signed [SUM_W-1:0]  dsum, ddiff;
   logic [TURN_W-1:0]        half_r, full_r;
   logic signed [PROD2_W-1:0] m2_neg;
   logic signed [46:0]       nx, ny;
   logic                     out_free;

   ddo_cordic #(
      .TRIG_STEPS(TRIG_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (trig_angle),
      .done    (trig_done),
      .cos_q15 (trig_cos),
      .sin_q15 (trig_sin)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dpt_in       = dpt_ff;
      apt_in       = apt_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_hd_in    = cur_hd_ff;
      last_l_in    = last_l_ff;
      last_r_in    = last_r_ff;
      m1_acc_in    = m1_acc_ff;
      m1_mc_in     = m1_mc_ff;
      m1_mp_in     = m1_mp_ff;
      t_acc_in     = t_acc_ff;
      t_mc_in      = t_mc_ff;
      t_mp_in      = t_mp_ff;
      full_in      = full_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      m2_mc_in     = m2_mc_ff;
      cx_in        = cx_ff;
      sy_in        = sy_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_hd_in    = out_hd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      trig_start   = 1'b0;

      // Tick deltas wrap at 32 bits and are then taken as signed.
      dl    = req_left_count - last_l_ff;
      dr    = req_right_count - last_r_ff;
      dsum  = SUM_W'(signed'(dl)) + SUM_W'(signed'(dr));
      ddiff = SUM_W'(signed'(dr)) - SUM_W'(signed'(dl));

      // Only the low bits of the turn product reach the 16-bit heading.
      half_r     = t_acc_ff + TURN_W'(256);
      full_r     = t_acc_ff + TURN_W'(128);
      trig_angle = cur_hd_ff + half_r[24:9];

      // The sign bit of the cosine or sine weighs negative.
      m2_neg = (cnt_ff == MUL2_LAST) ? -m2_mc_ff : m2_mc_ff;

      // The products were seeded with the rounding constant, so dx and dy are slices.
      nx = 47'(cur_x_ff) + 47'(signed'(ax_ff[PROD2_W-1:15]));
      ny = 47'(cur_y_ff) + 47'(signed'(ay_ff[PROD2_W-1:15]));

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_l_in = req_left_count;
               last_r_in = req_right_count;
               m1_acc_in = PROD1_W'(256);
               m1_mc_in  = PROD1_W'(dsum);
               m1_mp_in  = dpt_ff;
               t_acc_in  = '0;
               t_mc_in   = ddiff[TURN_W-1:0];
               t_mp_in   = apt_ff;
               cnt_in    = '0;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1: begin
            if (m1_mp_ff[0]) begin
               m1_acc_in = m1_acc_ff + m1_mc_ff;
            end
            if (t_mp_ff[0]) begin
               t_acc_in = t_acc_ff + t_mc_ff;
            end
            m1_mc_in = m1_mc_ff <<< 1;
            m1_mp_in = m1_mp_ff >> 1;
            t_mc_in  = t_mc_ff << 1;
            t_mp_in  = t_mp_ff >> 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL1_LAST) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            full_in    = full_r[23:8];
            m2_mc_in   = PROD2_W'(signed'(m1_acc_ff[PROD1_W-1:9]));
            ax_in      = PROD2_W'(16384);
            ay_in      = PROD2_W'(16384);
            trig_start = 1'b1;
            state_in   = ST_TRIG;
         end
         ST_TRIG: begin
            if (trig_done) begin
               cx_in    = trig_cos;
               sy_in    = trig_sin;
               cnt_in   = '0;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (cx_ff[0]) begin
               ax_in = ax_ff + m2_neg;
            end
            if (sy_ff[0]) begin
               ay_in = ay_ff + m2_neg;
            end
            m2_mc_in = m2_mc_ff <<< 1;
            cx_in    = cx_ff >> 1;
            sy_in    = sy_ff >> 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL2_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (nx[46:31] != {16{nx[46]}}) begin
                  cur_x_in = nx[46] ? 32'sh80000000 : 32'sh7FFFFFFF;
               end else begin
                  cur_x_in = nx[31:0];
               end
               if (ny[46:31] != {16{ny[46]}}) begin
                  cur_y_in = ny[46] ? 32'sh80000000 : 32'sh7FFFFFFF;
               end else begin
                  cur_y_in = ny[31:0];
               end
               cur_hd_in    = cur_hd_ff + full_ff;
               out_x_in     = cur_x_in;
               out_y_in     = cur_y_in;
               out_hd_in    = cur_hd_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes must arrive only while the block is idle; the block itself does not enforce it.
      if (csr_write) begin
         case (csr_index)
            REG_DIST_PER_TICK:  dpt_in    = csr_data[19:0];
            REG_ANGLE_PER_TICK: apt_in    = csr_data[15:0];
            REG_INITIAL_X:      cur_x_in  = csr_data;
            REG_INITIAL_Y:      cur_y_in  = csr_data;
            REG_INITIAL_HEAD:   cur_hd_in = csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         dpt_ff       <= 20'd28149;
         apt_ff       <= 16'd4096;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cur_hd_ff    <= '0;
         last_l_ff    <= '0;
         last_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dpt_ff       <= dpt_in;
         apt_ff       <= apt_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cur_hd_ff    <= cur_hd_in;
         last_l_ff    <= last_l_in;
         last_r_ff    <= last_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m1_acc_ff <= m1_acc_in;
      m1_mc_ff  <= m1_mc_in;
      m1_mp_ff  <= m1_mp_in;
      t_acc_ff  <= t_acc_in;
      t_mc_ff   <= t_mc_in;
      t_mp_ff   <= t_mp_in;
      full_ff   <= full_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      m2_mc_ff  <= m2_mc_in;
      cx_ff     <= cx_in;
      sy_ff     <= sy_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_hd_ff <= out_hd_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = out_x_ff;
   assign rsp_pos_y   = out_y_ff;
   assign rsp_heading = out_hd_ff;

`ifndef SYNTHESIS
   // The rotation unit reports only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      trig_done |-> state_ff == ST_TRIG)
      else $error("rotation result outside the wait state");

   // An accepted word starts the first multiply from step zero.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL1 && cnt_ff == 5'd0)
      else $error("accepted word did not start the multiply");

   // A finished update with room at the output shows a result and frees the input.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished update not delivered");
`endif

endmodule
`default_nettype wire
